@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the header sniffer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

@@ rtl/core/ihss_pkg.sv @@
// Types and constants for the image header size sniffer.
// No dependencies; imported by the core and its checker.
`default_nettype none

package ihss_pkg;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_MARKER,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_SOF,
      PH_STOP
   } jpeg_phase_type;

   localparam int FMT_W = 3;
   localparam int DIM_W = 31;

   localparam logic [FMT_W-1:0] FMT_UNKNOWN       = 3'd0;
   localparam logic [FMT_W-1:0] FMT_PNG           = 3'd1;
   localparam logic [FMT_W-1:0] FMT_JPEG          = 3'd2;
   localparam logic [FMT_W-1:0] FMT_WEBP_LOSSY    = 3'd3;
   localparam logic [FMT_W-1:0] FMT_WEBP_LOSSLESS = 3'd4;

   localparam int HEAD_DEPTH = 32;
   localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);

   localparam int MIN_LEN  = 8;
   localparam int PNG_LEN  = 24;
   localparam int WEBP_LEN = 30;
   localparam int SOF_SPAN = 9;

   localparam logic [7:0] MRK_PREFIX = 8'hFF;
   localparam logic [7:0] MRK_SOI    = 8'hD8;
   localparam logic [7:0] MRK_EOI    = 8'hD9;
   localparam logic [7:0] MRK_SOS    = 8'hDA;
   localparam logic [7:0] MRK_SOF0   = 8'hC0;
   localparam logic [7:0] MRK_SOF1   = 8'hC1;
   localparam logic [7:0] MRK_SOF2   = 8'hC2;

   localparam logic [31:0] TAG_PNG  = {8'h89, "PNG"};
   localparam logic [31:0] TAG_RIFF = "RIFF";
   localparam logic [31:0] TAG_WEBP = "WEBP";
   localparam logic [31:0] TAG_VP8  = "VP8 ";
   localparam logic [31:0] TAG_VP8L = "VP8L";
   localparam logic [23:0] VP8_START_CODE = 24'h9D012A;

   localparam logic [13:0] VP8L_DIM_MAX = 14'h3FFF;

endpackage

`default_nettype wire

@@ rtl/core/image_header_size_sniffer_core.sv @@
// Image header size sniffer: PNG, JPEG and WebP dimension parser, top level.
// Depends on ihss_pkg.
//
//   Channel | Direction | Handshake         | Beat
//   req     | in        | req_valid / ready | one header byte plus last flag
//   rsp     | out       | rsp_valid / ready | format, width and height
//
// A byte is registered on acceptance and processed in the next cycle; one byte per cycle
// unless a last byte is held. A last byte's result is registered in the output register.
// Bytes without a last flag flow on while a result waits on rsp_ready.
// A last byte waits in the input register only while the output register is full.
// Synchronous active-high reset clears the stream state and both valid flags.
`default_nettype none

module image_header_size_sniffer_core
   import ihss_pkg::*;
#(
   parameter int MAX_HEADER_BYTES = 65536
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_last_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [FMT_W-1:0]      rsp_image_format,
   output logic [DIM_W-1:0]      rsp_image_width,
   output logic [DIM_W-1:0]      rsp_image_height
);

   localparam int CNT_W = $clog2(MAX_HEADER_BYTES + 1);
   localparam int POS_W = $clog2(MAX_HEADER_BYTES + 65540);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             in_last_ff, in_last_in;
   logic             take;

   logic [7:0]       head_ff [HEAD_DEPTH];
   logic [7:0]       head_in [HEAD_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in, count_upd;
   jpeg_phase_type   phase_ff, phase_in, phase_upd;
   logic [POS_W-1:0] marker_ff, marker_in, marker_upd;
   logic [15:0]      seglen_ff, seglen_in, seglen_upd;
   logic [POS_W-1:0] sof_pos_ff, sof_pos_in, sof_pos_upd;
   logic [15:0]      sof_h_ff, sof_h_in, sof_h_upd;
   logic [15:0]      sof_w_ff, sof_w_in, sof_w_upd;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [FMT_W-1:0] fmt_ff, fmt_in, fmt_calc;
   logic [DIM_W-1:0] width_ff, width_in, width_calc;
   logic [DIM_W-1:0] height_ff, height_in, height_calc;

   logic             below_cap;
   logic [POS_W-1:0] pos_ext;
   logic [POS_W-1:0] sof_off;
   logic [15:0]      seglen_full;
   logic [16:0]      marker_step;
   logic [31:0]      png_w, png_h, vp8l_bits;
   logic [POS_W:0]   sof_end;

   assign take      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (take) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_last_in  = req_last_byte;
      end
   end

   // Stream state update for the byte in the input register.
   always_comb begin
      below_cap   = count_ff < CNT_W'(MAX_HEADER_BYTES);
      pos_ext     = POS_W'(count_ff);
      sof_off     = pos_ext - sof_pos_ff;
      seglen_full = {seglen_ff[15:8], in_byte_ff};
      marker_step = (seglen_full < 16'd2) ? 17'd4 : 17'd2 + {1'b0, seglen_full};
      head_in     = head_ff;
      count_upd   = count_ff;
      phase_upd   = phase_ff;
      marker_upd  = marker_ff;
      seglen_upd  = seglen_ff;
      sof_pos_upd = sof_pos_ff;
      sof_h_upd   = sof_h_ff;
      sof_w_upd   = sof_w_ff;
      if (take && below_cap) begin
         count_upd = count_ff + CNT_W'(1);
         if (count_ff < CNT_W'(HEAD_DEPTH)) begin
            head_in[count_ff[HEAD_IDX_W-1:0]] = in_byte_ff;
         end
         if (count_ff >= CNT_W'(2)) begin
            case (phase_ff)
               PH_SEARCH: begin
                  if (pos_ext == marker_ff) begin
                     if (in_byte_ff == MRK_PREFIX) begin
                        phase_upd = PH_MARKER;
                     end else begin
                        marker_upd = pos_ext + POS_W'(1);
                     end
                  end
               end
               PH_MARKER: begin
                  if (in_byte_ff == MRK_EOI || in_byte_ff == MRK_SOS) begin
                     phase_upd = PH_STOP;
                  end else if (in_byte_ff == MRK_SOF0 || in_byte_ff == MRK_SOF1 ||
                               in_byte_ff == MRK_SOF2) begin
                     sof_pos_upd = marker_ff;
                     phase_upd   = PH_SOF;
                  end else begin
                     phase_upd = PH_LEN_HI;
                  end
               end
               PH_LEN_HI: begin
                  seglen_upd = {in_byte_ff, 8'h00};
                  phase_upd  = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  seglen_upd = seglen_full;
                  marker_upd = marker_ff + POS_W'(marker_step);
                  phase_upd  = PH_SEARCH;
               end
               PH_SOF: begin
                  if (sof_off == POS_W'(5)) begin
                     sof_h_upd = {in_byte_ff, 8'h00};
                  end else if (sof_off == POS_W'(6)) begin
                     sof_h_upd = {sof_h_ff[15:8], in_byte_ff};
                  end else if (sof_off == POS_W'(7)) begin
                     sof_w_upd = {in_byte_ff, 8'h00};
                  end else if (sof_off == POS_W'(8)) begin
                     sof_w_upd = {sof_w_ff[15:8], in_byte_ff};
                     phase_upd = PH_STOP;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Classification on the updated state.
   always_comb begin
      png_w     = {head_in[16], head_in[17], head_in[18], head_in[19]};
      png_h     = {head_in[20], head_in[21], head_in[22], head_in[23]};
      vp8l_bits = {head_in[24], head_in[23], head_in[22], head_in[21]};
      sof_end   = {1'b0, sof_pos_upd} + (POS_W+1)'(SOF_SPAN);
      fmt_calc    = FMT_UNKNOWN;
      width_calc  = '0;
      height_calc = '0;
      if (count_upd >= CNT_W'(MIN_LEN)) begin
         if ({head_in[0], head_in[1], head_in[2], head_in[3]} == TAG_PNG &&
             count_upd >= CNT_W'(PNG_LEN)) begin
            fmt_calc    = FMT_PNG;
            width_calc  = png_w[31] ? '1 : png_w[DIM_W-1:0];
            height_calc = png_h[31] ? '1 : png_h[DIM_W-1:0];
         end else if (head_in[0] == MRK_PREFIX && head_in[1] == MRK_SOI) begin
            if (phase_upd == PH_STOP && sof_pos_upd != '0 &&
                sof_end < (POS_W+1)'(count_upd)) begin
               fmt_calc    = FMT_JPEG;
               width_calc  = DIM_W'(sof_w_upd);
               height_calc = DIM_W'(sof_h_upd);
            end
         end else if (count_upd >= CNT_W'(WEBP_LEN) &&
                      {head_in[0], head_in[1], head_in[2], head_in[3]} == TAG_RIFF &&
                      {head_in[8], head_in[9], head_in[10], head_in[11]} == TAG_WEBP) begin
            if ({head_in[12], head_in[13], head_in[14], head_in[15]} == TAG_VP8 &&
                {head_in[23], head_in[24], head_in[25]} == VP8_START_CODE) begin
               fmt_calc    = FMT_WEBP_LOSSY;
               width_calc  = DIM_W'({head_in[27][5:0], head_in[26]});
               height_calc = DIM_W'({head_in[29][5:0], head_in[28]});
            end else if ({head_in[12], head_in[13], head_in[14], head_in[15]} == TAG_VP8L) begin
               fmt_calc    = FMT_WEBP_LOSSLESS;
               width_calc  = DIM_W'({1'b0, vp8l_bits[13:0] & VP8L_DIM_MAX} + 15'd1);
               height_calc = DIM_W'({1'b0, vp8l_bits[27:14] & VP8L_DIM_MAX} + 15'd1);
            end
         end
      end
   end

   always_comb begin
      count_in   = count_upd;
      phase_in   = phase_upd;
      marker_in  = marker_upd;
      seglen_in  = seglen_upd;
      sof_pos_in = sof_pos_upd;
      sof_h_in   = sof_h_upd;
      sof_w_in   = sof_w_upd;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      fmt_in       = fmt_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (take && in_last_ff) begin
         count_in     = '0;
         phase_in     = PH_SEARCH;
         marker_in    = POS_W'(2);
         seglen_in    = '0;
         sof_pos_in   = '0;
         sof_h_in     = '0;
         sof_w_in     = '0;
         rsp_valid_in = 1'b1;
         fmt_in       = fmt_calc;
         width_in     = width_calc;
         height_in    = height_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         phase_ff     <= PH_SEARCH;
         marker_ff    <= POS_W'(2);
         seglen_ff    <= '0;
         sof_pos_ff   <= '0;
         sof_h_ff     <= '0;
         sof_w_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         marker_ff    <= marker_in;
         seglen_ff    <= seglen_in;
         sof_pos_ff   <= sof_pos_in;
         sof_h_ff     <= sof_h_in;
         sof_w_ff     <= sof_w_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      head_ff    <= head_in;
      fmt_ff     <= fmt_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_image_format = fmt_ff;
   assign rsp_image_width  = width_ff;
   assign rsp_image_height = height_ff;

endmodule

`default_nettype wire

@@ rtl/core/ihss_checker.sv @@
// Port-level checker for the image header size sniffer, bound to the core.
// Depends on ihss_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ihss_checker
   import ihss_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [FMT_W-1:0] rsp_image_format,
   input wire logic [DIM_W-1:0] rsp_image_width,
   input wire logic [DIM_W-1:0] rsp_image_height
);

   localparam logic [DIM_W-1:0] WEBP_DIM_TOP = DIM_W'(16384);

   logic                       rsp_stall;
   logic                       unknown_fmt;
   logic                       webp_fmt;
   logic                       dims_zero;
   logic                       webp_fits;
   logic [FMT_W+2*DIM_W-1:0]   rsp_beat;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign unknown_fmt = rsp_image_format == FMT_UNKNOWN;
   assign webp_fmt    = rsp_image_format == FMT_WEBP_LOSSY ||
                        rsp_image_format == FMT_WEBP_LOSSLESS;
   assign dims_zero   = rsp_image_width == '0 && rsp_image_height == '0;
   assign webp_fits   = rsp_image_width <= WEBP_DIM_TOP && rsp_image_height <= WEBP_DIM_TOP;
   assign rsp_beat    = {rsp_image_format, rsp_image_width, rsp_image_height};

   `ASSERT_CLK(a_no_rsp_after_reset, clock, reset |=> !rsp_valid)
   `ASSERT_CLK(a_ready_after_reset, clock, reset |=> req_ready)
   `ASSERT_CLK_RST(a_rsp_holds, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_beat))
   `ASSERT_CLK_RST(a_unknown_zero, clock, reset, rsp_valid && unknown_fmt |-> dims_zero)
   `ASSERT_CLK_RST(a_webp_range, clock, reset, rsp_valid && webp_fmt |-> webp_fits)

endmodule

bind image_header_size_sniffer_core ihss_checker u_ihss_checker (.*);

`default_nettype wire
